// File: hw/rtl/pbsa_pkg.sv
package pbsa_pkg;

    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [IDX_W-1:0]  ROM_INDEX    = 3'd6;
    localparam logic [ADDR_W-1:0] IO_LOW_BITS  = 32'h0000_0003;
    localparam logic [ADDR_W-1:0] MEM_LOW_BITS = 32'h0000_000F;
    localparam logic [ADDR_W-1:0] PAGE_ROUND   = 32'h0000_0FFF;

    // memory type field of a memory BAR
    localparam logic [1:0] MEM_TYPE_32 = 2'b00;
    localparam logic [1:0] MEM_TYPE_64 = 2'b10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IO_BASE  = 1'b1;

    typedef enum logic [1:0] {
        OUT_ASSIGNED    = 2'd0,
        OUT_ROM_SKIPPED = 2'd1,
        OUT_RESERVED    = 2'd2,
        OUT_ABSENT      = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        KIND_MEM32 = 2'd0,
        KIND_IO    = 2'd1,
        KIND_MEM64 = 2'd2
    } t_kind;

    // decoded view of one BAR, passed from decoder to allocator
    typedef struct packed {
        t_outcome          outcome;
        t_kind             kind;
        logic [ADDR_W-1:0] size;
    } t_decode;

endpackage

// File: hw/rtl/pbsa_req_if.sv
interface pbsa_req_if;
    import pbsa_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  register_index;
    logic [ADDR_W-1:0] original_value;
    logic [ADDR_W-1:0] probe_readback;

    modport source (
        output valid, register_index, original_value, probe_readback,
        input  ready
    );
    modport sink (
        input  valid, register_index, original_value, probe_readback,
        output ready
    );
endinterface

// File: hw/rtl/pbsa_res_if.sv
interface pbsa_res_if;
    import pbsa_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        outcome;
    logic [1:0]        region_kind;
    logic [ADDR_W-1:0] assigned_address;
    logic [ADDR_W-1:0] region_size;
    logic              set_io_enable;
    logic              set_memory_enable;

    modport source (
        output valid, outcome, region_kind, assigned_address, region_size,
               set_io_enable, set_memory_enable,
        input  ready
    );
    modport sink (
        input  valid, outcome, region_kind, assigned_address, region_size,
               set_io_enable, set_memory_enable,
        output ready
    );
endinterface

// File: hw/rtl/pbsa_decode.sv
module pbsa_decode
    import pbsa_pkg::*;
(
    input  logic [IDX_W-1:0]  i_register_index,
    input  logic [ADDR_W-1:0] i_original_value,
    input  logic [ADDR_W-1:0] i_probe_readback,
    output t_decode           o_dec
);

    logic              reserved;
    t_kind             kind;
    logic [ADDR_W-1:0] masked;
    logic [ADDR_W-1:0] size;

    // space and type decode
    always_comb begin
        reserved = 1'b0;
        kind     = KIND_MEM32;
        if (i_original_value[0]) begin
            kind = KIND_IO;
        end else begin
            case (i_original_value[2:1])
                MEM_TYPE_32: kind = KIND_MEM32;
                MEM_TYPE_64: kind = KIND_MEM64;
                default:     reserved = 1'b1;
            endcase
        end
    end

    // size is the two's complement of the masked readback
    assign masked = (kind == KIND_IO) ? (i_probe_readback & ~IO_LOW_BITS)
                                      : (i_probe_readback & ~MEM_LOW_BITS);
    assign size   = ~masked + ADDR_W'(1);

    // outcome selection, ROM first
    always_comb begin
        o_dec.outcome = OUT_ASSIGNED;
        o_dec.kind    = KIND_MEM32;
        o_dec.size    = '0;
        if (i_register_index == ROM_INDEX) begin
            o_dec.outcome = OUT_ROM_SKIPPED;
        end else if (reserved) begin
            o_dec.outcome = OUT_RESERVED;
        end else if (size == '0) begin
            o_dec.outcome = OUT_ABSENT;
            o_dec.kind    = kind;
        end else begin
            o_dec.kind = kind;
            o_dec.size = size;
        end
    end

endmodule

// File: hw/rtl/pbsa_alloc.sv
module pbsa_alloc
    import pbsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_wdata,
    input  logic                 i_adv,
    input  t_decode              i_dec,
    output logic [ADDR_W-1:0]    o_addr
);

    logic [ADDR_W-1:0] r_mem_base;
    logic [ADDR_W-1:0] r_io_base;
    logic [ADDR_W-1:0] r_mem_ptr, n_mem_ptr;
    logic [ADDR_W-1:0] r_io_ptr,  n_io_ptr;
    logic [ADDR_W-1:0] eff_mem, eff_io;
    logic [ADDR_W-1:0] mem_step;
    logic              assign_io, assign_mem;

    // a pointer reading zero restarts at its window base
    assign eff_mem = (r_mem_ptr == '0) ? r_mem_base : r_mem_ptr;
    assign eff_io  = (r_io_ptr  == '0) ? r_io_base  : r_io_ptr;

    // memory advances in whole 4 KiB pages, wrapping at 32 bits
    assign mem_step = (i_dec.size + PAGE_ROUND) & ~PAGE_ROUND;

    assign assign_io  = (i_dec.outcome == OUT_ASSIGNED) && (i_dec.kind == KIND_IO);
    assign assign_mem = (i_dec.outcome == OUT_ASSIGNED) && (i_dec.kind != KIND_IO);

    always_comb begin
        o_addr = '0;
        if (assign_io) begin
            o_addr = eff_io;
        end else if (assign_mem) begin
            o_addr = eff_mem;
        end
    end

    // pointer update as the request leaves the input register
    always_comb begin
        n_mem_ptr = r_mem_ptr;
        n_io_ptr  = r_io_ptr;
        if (i_adv) begin
            n_mem_ptr = assign_mem ? (eff_mem + mem_step)   : eff_mem;
            n_io_ptr  = assign_io  ? (eff_io + i_dec.size) : eff_io;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_base <= '0;
            r_io_base  <= '0;
            r_mem_ptr  <= '0;
            r_io_ptr   <= '0;
        end else begin
            r_mem_ptr <= n_mem_ptr;
            r_io_ptr  <= n_io_ptr;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MEM_BASE: r_mem_base <= i_cfg_wdata;
                    CFG_IO_BASE:  r_io_base  <= i_cfg_wdata;
                    default:      ;
                endcase
            end
        end
    end

    // I/O assignment moves only the I/O pointer, by the exact size
    a_io_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && assign_io) |=>
            (r_io_ptr == $past(eff_io + i_dec.size)) && (r_mem_ptr == $past(eff_mem)))
        else $error("I/O pointer update wrong");

    // memory assignment moves only the memory pointer, page aligned step
    a_mem_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && assign_mem) |=>
            ((r_mem_ptr - $past(eff_mem)) & PAGE_ROUND) == '0 &&
            (r_io_ptr == $past(eff_io)))
        else $error("memory pointer update wrong");

    // skipped, rejected and absent registers only reload
    a_no_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (i_dec.outcome != OUT_ASSIGNED)) |=>
            (r_mem_ptr == $past(eff_mem)) && (r_io_ptr == $past(eff_io)))
        else $error("pointer moved without an assignment");

    // pointers hold while no request moves on
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_mem_ptr) && $stable(r_io_ptr))
        else $error("pointer changed while idle");

endmodule

// File: hw/rtl/pci_bar_size_and_assign_unit.sv
// BAR sizing and address assignment. One request per clock is accepted
// unless the result register holds a result not yet taken and the input
// register is full. A request passes through the input register, then the
// result register, from which its result is offered. The rate is set by the
// pointer update: after the size decode come the page rounding add and the
// pointer add, which lie between the two registers. The result register
// lets a new request in while a finished result still waits to be taken.
// The user must write window bases only while no request is in flight; the
// block itself does not enforce this.
module pci_bar_size_and_assign_unit
    import pbsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pbsa_req_if.sink             i_req,
    pbsa_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_wdata
);

    logic              r_in_vld;
    logic [IDX_W-1:0]  r_idx;
    logic [ADDR_W-1:0] r_orig;
    logic [ADDR_W-1:0] r_rb;

    logic              r_out_vld;
    t_outcome          r_outcome;
    t_kind             r_kind;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_size;
    logic              r_io_en;
    logic              r_mem_en;

    logic              adv;
    t_decode           dec;
    logic [ADDR_W-1:0] addr;

    // the input register moves on when the result slot is free or emptying
    assign adv         = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_req.ready = !r_in_vld || !r_out_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_idx  <= i_req.register_index;
            r_orig <= i_req.original_value;
            r_rb   <= i_req.probe_readback;
        end
    end

    pbsa_decode u_decode (
        .i_register_index (r_idx),
        .i_original_value (r_orig),
        .i_probe_readback (r_rb),
        .o_dec            (dec)
    );

    pbsa_alloc u_alloc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (adv),
        .i_dec       (dec),
        .o_addr      (addr)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || o_res.ready) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_outcome <= dec.outcome;
            r_kind    <= dec.kind;
            r_addr    <= addr;
            r_size    <= dec.size;
            r_io_en   <= (dec.outcome == OUT_ASSIGNED) && (dec.kind == KIND_IO);
            r_mem_en  <= (dec.outcome == OUT_ASSIGNED) && (dec.kind != KIND_IO);
        end
    end

    assign o_res.valid             = r_out_vld;
    assign o_res.outcome           = r_outcome;
    assign o_res.region_kind       = r_kind;
    assign o_res.assigned_address  = r_addr;
    assign o_res.region_size       = r_size;
    assign o_res.set_io_enable     = r_io_en;
    assign o_res.set_memory_enable = r_mem_en;

endmodule
